>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the pointer report block.
// No dependencies; each macro collapses to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Implication or plain property checked on every rising edge outside reset.
`define APR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error("pointer report assertion failed");

// Condition that must never be true outside reset.
`define APR_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("pointer report forbidden condition seen");

`else

`define APR_ASSERT(lbl, clk, rst_n, prop)
`define APR_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

>>> rtl/apr_pkg.sv
// Package for the absolute pointer report block: item structs, register
// indexes, widths and reset values. No dependencies.
package apr_pkg;

	localparam int unsigned AXIS_MAX_DEF = 32767;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned SIZE_W     = 16;
	localparam int unsigned ABS_W      = 15;
	localparam int unsigned WHEEL_W    = 8;
	localparam int unsigned BTN_W      = 3;
	localparam int unsigned SENT_BTN_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_LINK_ENABLE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd2;

	localparam logic [SIZE_W-1:0]     WIDTH_RST      = 16'd1920;
	localparam logic [SIZE_W-1:0]     HEIGHT_RST     = 16'd1080;
	localparam logic [SENT_BTN_W-1:0] SENT_BTN_FORCE = 8'hFF;

	localparam logic signed [15:0] WHEEL_POS_LIM = 16'sd127;
	localparam logic signed [15:0] WHEEL_NEG_LIM = -16'sd127;

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [BTN_W-1:0]   button_mask;
		logic signed [15:0] scroll_step;
	} apr_in_t;

	typedef struct packed {
		logic [BTN_W-1:0]          buttons;
		logic [ABS_W-1:0]          abs_x;
		logic [ABS_W-1:0]          abs_y;
		logic signed [WHEEL_W-1:0] wheel;
	} apr_out_t;

endpackage

>>> rtl/absolute_pointer_report_synth_top.sv
// Absolute pointer report synthesizer, top level and only module.
// Depends on apr_pkg and assert_macros.svh.
`include "assert_macros.svh"

// - in_valid/in_ready/in_item carry one pointer event per item. in_ready is
//   high only while the block is idle; a dropped event (link down, width or
//   height of 0 or 1) is taken and discarded in that same cycle.
// - out_valid/out_ready/out_item carry one report item. A report is made
//   when the scaled position or the buttons differ from the last report, or
//   when the wheel is nonzero; otherwise the event leaves no result.
// - cfg_we/cfg_index/cfg_data write link_enable (0), screen_width (1) and
//   screen_height (2) at once; other indexes are ignored. Write only while
//   idle. Raising link_enable forces the next event to report.
// - Each axis is scaled by a constant product loaded into a restoring divider
//   that yields one quotient bit per cycle; both axes share the divider, and
//   each quotient has QW = bits of AXIS_MAX bits (15 at the default). An item
//   is accepted in idle, then gets a load and the quotient steps per axis and
//   a report step, which may hold; no new event is taken until it ends.
//   The report, if any, and in_ready both appear when the report step ends.
// - The report waits in an output register. A stalled receiver holds the
//   block only when the next report is ready; events with no result pass.
// - arst_n clears the control state, loads the register reset values and
//   sets the last buttons to all ones so that the first event reports.
module absolute_pointer_report_synth_top
	import apr_pkg::*;
#(
	parameter int unsigned AXIS_MAX = AXIS_MAX_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  apr_in_t               in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output apr_out_t              out_item,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Quotient width, product width and quotient bit counter width.
	localparam int unsigned QW = $clog2(AXIS_MAX + 1);
	localparam int unsigned PW = SIZE_W + QW;
	localparam int unsigned CW = $clog2(QW + 1);
	localparam logic [QW-1:0] AXIS_K   = QW'(AXIS_MAX);
	localparam logic [CW-1:0] CNT_LAST = CW'(QW - 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} apr_state_t;

	apr_state_t state_q;

	// Configuration registers.
	logic              link_en_q;
	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;

	// Last report sent.
	logic [ABS_W-1:0]      sent_x_q;
	logic [ABS_W-1:0]      sent_y_q;
	logic [SENT_BTN_W-1:0] sent_btn_q;

	// Event being worked on.
	logic [SIZE_W-1:0]         cx_q;
	logic [SIZE_W-1:0]         cy_q;
	logic [BTN_W-1:0]          btn_q;
	logic signed [WHEEL_W-1:0] wheel_q;
	logic                      axis_y_q;

	// Divider.
	logic [SIZE_W-1:0] rem_q;
	logic [QW-1:0]     low_q;
	logic [QW-1:0]     quo_q;
	logic [CW-1:0]     cnt_q;
	logic [ABS_W-1:0]  ax_q;
	logic [ABS_W-1:0]  ay_q;

	// Output register.
	logic     out_valid_q;
	apr_out_t out_q;

	logic              accept;
	logic              drop;
	logic [SIZE_W-1:0] span_w;
	logic [SIZE_W-1:0] span_h;
	logic [SIZE_W-1:0] span;
	logic [SIZE_W-1:0] cx_clamp;
	logic [SIZE_W-1:0] cy_clamp;
	logic signed [WHEEL_W-1:0] wheel_sat;
	logic [PW-1:0]     prod;
	logic [SIZE_W:0]   trial;
	logic [SIZE_W:0]   diff;
	logic              qbit;
	logic [QW-1:0]     quo_next;
	logic [ABS_W+QW-1:0] quo_ext;
	logic [ABS_W-1:0]  quo_abs;
	logic              changed;
	logic              out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign out_free  = !out_valid_q || out_ready;

	assign span_w = width_q - SIZE_W'(1);
	assign span_h = height_q - SIZE_W'(1);
	assign span   = axis_y_q ? span_h : span_w;

	// Drop the event while the link is down or the area is degenerate.
	assign drop = !link_en_q || (width_q[SIZE_W-1:1] == '0) || (height_q[SIZE_W-1:1] == '0);

	// Clamp each coordinate to 0..size-1.
	always_comb begin
		if (in_item.pos_x[15]) begin
			cx_clamp = '0;
		end else if ($unsigned(in_item.pos_x) > span_w) begin
			cx_clamp = span_w;
		end else begin
			cx_clamp = $unsigned(in_item.pos_x);
		end
		if (in_item.pos_y[15]) begin
			cy_clamp = '0;
		end else if ($unsigned(in_item.pos_y) > span_h) begin
			cy_clamp = span_h;
		end else begin
			cy_clamp = $unsigned(in_item.pos_y);
		end
	end

	// Saturate the wheel to plus or minus 127.
	always_comb begin
		if (in_item.scroll_step > WHEEL_POS_LIM) begin
			wheel_sat = WHEEL_W'(WHEEL_POS_LIM);
		end else if (in_item.scroll_step < WHEEL_NEG_LIM) begin
			wheel_sat = WHEEL_W'(WHEEL_NEG_LIM);
		end else begin
			wheel_sat = in_item.scroll_step[WHEEL_W-1:0];
		end
	end

	// Scale numerator for the current axis; the quotient is at most AXIS_MAX,
	// so the top SIZE_W bits already sit below the divisor.
	assign prod = PW'(axis_y_q ? cy_q : cx_q) * PW'(AXIS_K);

	// One restoring division step: bring down the next numerator bit.
	assign trial    = {rem_q, low_q[QW-1]};
	assign diff     = trial - {1'b0, span};
	assign qbit     = (trial >= {1'b0, span});
	assign quo_next = {quo_q[QW-2:0], qbit};
	assign quo_ext  = {{ABS_W{1'b0}}, quo_next};
	assign quo_abs  = quo_ext[ABS_W-1:0];

	assign changed = (ax_q != sent_x_q) || (ay_q != sent_y_q)
		|| ({{(SENT_BTN_W-BTN_W){1'b0}}, btn_q} != sent_btn_q)
		|| (wheel_q != '0);

	// Control: accept, scale x, scale y, compare and report.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			axis_y_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && !drop) begin
						axis_y_q <= 1'b0;
						state_q  <= ST_MUL;
					end
				end
				ST_MUL: begin
					cnt_q   <= CNT_LAST;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						if (axis_y_q) begin
							state_q <= ST_DONE;
						end else begin
							axis_y_q <= 1'b1;
							state_q  <= ST_MUL;
						end
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				ST_DONE: begin
					// Hold while an earlier report still waits.
					if (!changed || out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Event capture and divider datapath.
	always_ff @(posedge clk) begin
		if (accept) begin
			cx_q    <= cx_clamp;
			cy_q    <= cy_clamp;
			btn_q   <= in_item.button_mask;
			wheel_q <= wheel_sat;
		end
		if (state_q == ST_MUL) begin
			rem_q <= prod[PW-1:QW];
			low_q <= prod[QW-1:0];
			quo_q <= '0;
		end else if (state_q == ST_DIV) begin
			rem_q <= qbit ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
			low_q <= {low_q[QW-2:0], 1'b0};
			quo_q <= quo_next;
			if (cnt_q == '0) begin
				if (axis_y_q) begin
					ay_q <= quo_abs;
				end else begin
					ax_q <= quo_abs;
				end
			end
		end
	end

	// Configuration registers and last-sent state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_en_q  <= 1'b0;
			width_q    <= WIDTH_RST;
			height_q   <= HEIGHT_RST;
			sent_x_q   <= '0;
			sent_y_q   <= '0;
			sent_btn_q <= SENT_BTN_FORCE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LINK_ENABLE: begin
					if (cfg_data[0] && !link_en_q) begin
						sent_btn_q <= SENT_BTN_FORCE;
					end
					link_en_q <= cfg_data[0];
				end
				REG_SCREEN_WIDTH:  width_q  <= cfg_data;
				REG_SCREEN_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end else if (state_q == ST_DONE && changed && out_free) begin
			sent_x_q   <= ax_q;
			sent_y_q   <= ay_q;
			sent_btn_q <= {{(SENT_BTN_W-BTN_W){1'b0}}, btn_q};
		end
	end

	// Output register: load a report, drop it once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && changed && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && changed && out_free) begin
			out_q.buttons <= btn_q;
			out_q.abs_x   <= ax_q;
			out_q.abs_y   <= ay_q;
			out_q.wheel   <= wheel_q;
		end
	end

	// A pending report always matches the stored last-sent position.
	`APR_ASSERT(a_sent_matches_out, clk, arst_n,
		out_valid_q |-> (out_q.abs_x == sent_x_q && out_q.abs_y == sent_y_q))
	// The partial remainder stays below the divisor.
	`APR_ASSERT(a_rem_below_span, clk, arst_n, (state_q == ST_DIV) |-> (rem_q < span))
	// A dropped event leaves the block idle.
	`APR_ASSERT(a_drop_stays_idle, clk, arst_n, (accept && drop) |=> (state_q == ST_IDLE))
	// A new report never replaces one still waiting: hold until it is taken.
	`APR_ASSERT(a_no_overwrite, clk, arst_n,
		(state_q == ST_DONE && changed && !out_free) |=> (state_q == ST_DONE))
	// The state register stays one-hot.
	`APR_NEVER(a_state_onehot, clk, arst_n, !$onehot(state_q))

endmodule
